// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the i2c master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // input kind codes
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_START_WR = 2'd1;
    localparam logic [1:0] KIND_START_RD = 2'd2;
    localparam logic [1:0] KIND_DATA     = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_WAIT_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_POLL_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [7:0]  PHASE_TICKS_RST     = 8'd4;
    localparam logic [15:0] STOP_WAIT_TICKS_RST = 16'd1000;
    localparam logic [7:0]  ACK_POLL_LIMIT_RST  = 8'd255;

    // saturation point of the ack poll counter
    localparam logic [7:0] ACK_POLLS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_sample;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       need_data;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic       error;
    } rsp_t;

    // classified word handed from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic       is_read;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_sample;
    } cmd_word_t;

    typedef struct packed {
        logic      valid;
        cmd_word_t word;
    } cmd_chan_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts request words, classifies them and holds up to two for the sequencer.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  i2cm_pkg::req_t    req,
    input  logic              deq,
    output i2cm_pkg::cmd_chan_t chan
);
    import i2cm_pkg::*;

    cmd_word_t  head_reg;
    cmd_word_t  spare_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    cmd_word_t  cls;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        cls.slave_address    = req.slave_address;
        cls.register_address = req.register_address;
        cls.byte_count       = req.byte_count;
        cls.data_byte        = req.data_byte;
        cls.sda_sample       = req.sda_sample;
        cls.is_read          = 1'b0;
        case (req.kind)
            KIND_TICK:
            begin
                cls.cmd = CMD_TICK;
            end
            KIND_START_WR:
            begin
                cls.cmd = CMD_START;
            end
            KIND_START_RD:
            begin
                cls.cmd     = CMD_START;
                cls.is_read = 1'b1;
            end
            default:
            begin
                cls.cmd = CMD_DATA;
            end
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = deq && (cnt_reg != 2'd0);
    assign chan.valid = (cnt_reg != 2'd0);
    assign chan.word  = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_reg <= spare_reg;
                if (do_push)
                begin
                    spare_reg <= cls;
                end
            end
            else if (do_push)
            begin
                head_reg <= cls;
            end
        end
        else if (do_push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= cls;
            end
            else
            begin
                spare_reg <= cls;
            end
        end
    end

endmodule

// ===== rtl/core/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: one classified word per cycle while the response queue has room, one response word each.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  i2cm_pkg::cmd_chan_t                   chan,
    input  logic                                  out_full,
    output logic                                  fire,
    output i2cm_pkg::rsp_t                        rsp_word
);
    import i2cm_pkg::*;

    typedef enum logic [26:0] {
        ST_IDLE      = 27'h0000001,
        ST_S_A       = 27'h0000002,
        ST_S_B       = 27'h0000004,
        ST_S_C       = 27'h0000008,
        ST_S_D       = 27'h0000010,
        ST_W_BIT     = 27'h0000020,
        ST_W_HI      = 27'h0000040,
        ST_W_LO      = 27'h0000080,
        ST_A_PRE     = 27'h0000100,
        ST_A_REL     = 27'h0000200,
        ST_A_HI      = 27'h0000400,
        ST_A_POLL    = 27'h0000800,
        ST_A_OK      = 27'h0001000,
        ST_A_FAIL    = 27'h0002000,
        ST_DATA_WAIT = 27'h0004000,
        ST_R_PRE     = 27'h0008000,
        ST_R_REL     = 27'h0010000,
        ST_R_LO      = 27'h0020000,
        ST_R_HI      = 27'h0040000,
        ST_R_END     = 27'h0080000,
        ST_P_SET     = 27'h0100000,
        ST_P_HI      = 27'h0200000,
        ST_P_LO      = 27'h0400000,
        ST_T_LOW     = 27'h0800000,
        ST_T_HI      = 27'h1000000,
        ST_T_REL     = 27'h2000000,
        ST_T_WAIT    = 27'h4000000
    } step_t;

    typedef enum logic [1:0] {
        ROLE_ADDR = 2'd0,
        ROLE_SUB  = 2'd1,
        ROLE_DATA = 2'd2
    } role_t;

    // configuration
    logic [7:0]  phase_ticks_reg;
    logic [15:0] stop_wait_ticks_reg;
    logic [7:0]  ack_poll_limit_reg;

    step_t       step_reg,  step_next;
    logic [7:0]  pc_reg,    pc_next;
    logic [2:0]  reps_reg,  reps_next;
    logic [3:0]  bit_reg,   bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  left_reg,  left_next;
    logic [7:0]  polls_reg, polls_next;
    logic [15:0] swc_reg,   swc_next;
    logic        rd_reg,    rd_next;
    logic [6:0]  tgt_reg,   tgt_next;
    logic [7:0]  sub_reg,   sub_next;
    logic        scl_reg,   scl_next;
    logic        sda_reg,   sda_next;
    role_t       role_reg,  role_next;
    logic        fail_reg,  fail_next;

    logic        go;
    step_t       go_step;
    logic        ev_valid;
    logic [7:0]  ev_byte;
    logic        ev_done;
    logic [7:0]  pt_eff;
    logic [7:0]  limit;
    logic [7:0]  pc_dec;
    logic [7:0]  polls_inc;
    logic [15:0] swc_dec;
    cmd_word_t   w;

    assign fire   = chan.valid && !out_full;
    assign w      = chan.word;
    assign pt_eff = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign limit  = (ack_poll_limit_reg == 8'd0) ? 8'd1 : ack_poll_limit_reg;
    assign pc_dec = pc_reg - 8'd1;
    assign swc_dec = swc_reg - 16'd1;
    assign polls_inc = (polls_reg != ACK_POLLS_MAX) ? polls_reg + 8'd1 : polls_reg;

    always_comb
    begin
        step_next  = step_reg;
        pc_next    = pc_reg;
        reps_next  = reps_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        polls_next = polls_reg;
        swc_next   = swc_reg;
        rd_next    = rd_reg;
        tgt_next   = tgt_reg;
        sub_next   = sub_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        role_next  = role_reg;
        fail_next  = fail_reg;
        go         = 1'b0;
        go_step    = ST_IDLE;
        ev_valid   = 1'b0;
        ev_byte    = 8'd0;
        ev_done    = 1'b0;

        if (fire)
        begin
            case (w.cmd)
                CMD_TICK:
                begin
                    case (step_reg)
                        ST_IDLE, ST_DATA_WAIT:
                        begin
                            go = 1'b0;
                        end
                        ST_A_POLL:
                        begin
                            polls_next = polls_inc;
                            if (!w.sda_sample)
                            begin
                                go      = 1'b1;
                                go_step = ST_A_OK;
                            end
                            else if (polls_inc >= limit)
                            begin
                                fail_next = 1'b1;
                                go        = 1'b1;
                                go_step   = ST_A_FAIL;
                            end
                        end
                        ST_T_WAIT:
                        begin
                            swc_next = swc_dec;
                            if (swc_dec == 16'd0)
                            begin
                                step_next = ST_IDLE;
                                ev_done   = 1'b1;
                            end
                        end
                        default:
                        begin
                            pc_next = pc_dec;
                            if (pc_dec == 8'd0)
                            begin
                                if (reps_reg > 3'd1)
                                begin
                                    reps_next = reps_reg - 3'd1;
                                    pc_next   = pt_eff;
                                end
                                else
                                begin
                                    go = 1'b1;
                                    // phase expired: pick the next phase
                                    case (step_reg)
                                        ST_S_A:   go_step = ST_S_B;
                                        ST_S_B:   go_step = ST_S_C;
                                        ST_S_C:   go_step = ST_S_D;
                                        ST_S_D:
                                        begin
                                            shift_next = {tgt_reg, rd_reg};
                                            bit_next   = 4'd0;
                                            role_next  = ROLE_ADDR;
                                            go_step    = ST_W_BIT;
                                        end
                                        ST_W_BIT: go_step = ST_W_HI;
                                        ST_W_HI:  go_step = ST_W_LO;
                                        ST_W_LO:
                                        begin
                                            shift_next = {shift_reg[6:0], 1'b0};
                                            bit_next   = bit_reg + 4'd1;
                                            go_step    = (bit_next >= 4'd8) ? ST_A_PRE : ST_W_BIT;
                                        end
                                        ST_A_PRE: go_step = ST_A_REL;
                                        ST_A_REL: go_step = ST_A_HI;
                                        ST_A_HI:  go_step = ST_A_POLL;
                                        ST_A_OK:
                                        begin
                                            if (role_reg == ROLE_ADDR)
                                            begin
                                                bit_next = 4'd0;
                                                if (rd_reg)
                                                begin
                                                    shift_next = 8'd0;
                                                    go_step    = ST_R_PRE;
                                                end
                                                else
                                                begin
                                                    shift_next = sub_reg;
                                                    role_next  = ROLE_SUB;
                                                    go_step    = ST_W_BIT;
                                                end
                                            end
                                            else if (role_reg == ROLE_SUB)
                                            begin
                                                role_next = ROLE_DATA;
                                                go_step   = ST_DATA_WAIT;
                                            end
                                            else
                                            begin
                                                left_next = left_reg - 8'd1;
                                                go_step   = (left_next == 8'd0) ?
                                                            ST_T_LOW : ST_DATA_WAIT;
                                            end
                                        end
                                        ST_A_FAIL: go_step = ST_T_LOW;
                                        ST_R_PRE:  go_step = ST_R_REL;
                                        ST_R_REL:  go_step = ST_R_LO;
                                        ST_R_LO:   go_step = ST_R_HI;
                                        ST_R_HI:
                                        begin
                                            shift_next = {shift_reg[6:0], w.sda_sample};
                                            bit_next   = bit_reg + 4'd1;
                                            if (bit_next >= 4'd8)
                                            begin
                                                ev_valid  = 1'b1;
                                                ev_byte   = shift_next;
                                                left_next = left_reg - 8'd1;
                                                go_step   = ST_R_END;
                                            end
                                            else
                                            begin
                                                go_step = ST_R_LO;
                                            end
                                        end
                                        ST_R_END: go_step = ST_P_SET;
                                        ST_P_SET: go_step = ST_P_HI;
                                        ST_P_HI:  go_step = ST_P_LO;
                                        ST_P_LO:
                                        begin
                                            if (left_reg == 8'd0)
                                            begin
                                                go_step = ST_T_LOW;
                                            end
                                            else
                                            begin
                                                shift_next = 8'd0;
                                                bit_next   = 4'd0;
                                                go_step    = ST_R_PRE;
                                            end
                                        end
                                        ST_T_LOW: go_step = ST_T_HI;
                                        ST_T_HI:  go_step = ST_T_REL;
                                        ST_T_REL:
                                        begin
                                            if (stop_wait_ticks_reg == 16'd0)
                                            begin
                                                go        = 1'b0;
                                                step_next = ST_IDLE;
                                                ev_done   = 1'b1;
                                            end
                                            else
                                            begin
                                                go_step = ST_T_WAIT;
                                            end
                                        end
                                        default:
                                        begin
                                            go        = 1'b0;
                                            step_next = ST_IDLE;
                                        end
                                    endcase
                                end
                            end
                        end
                    endcase
                end
                CMD_START:
                begin
                    if (step_reg == ST_IDLE)
                    begin
                        fail_next = 1'b0;
                        if (w.byte_count == 8'd0)
                        begin
                            ev_done = 1'b1;
                        end
                        else
                        begin
                            tgt_next  = w.slave_address;
                            sub_next  = w.register_address;
                            left_next = w.byte_count;
                            rd_next   = w.is_read;
                            role_next = ROLE_ADDR;
                            go        = 1'b1;
                            go_step   = ST_S_A;
                        end
                    end
                end
                default:
                begin
                    if (step_reg == ST_DATA_WAIT)
                    begin
                        shift_next = w.data_byte;
                        bit_next   = 4'd0;
                        role_next  = ROLE_DATA;
                        go         = 1'b1;
                        go_step    = ST_W_BIT;
                    end
                end
            endcase
        end

        // phase entry: line changes and delay count of the new phase
        if (go)
        begin
            step_next = go_step;
            reps_next = 3'd1;
            pc_next   = pt_eff;
            case (go_step)
                ST_S_A:       scl_next = 1'b1;
                ST_S_B:       sda_next = 1'b1;
                ST_S_C:       sda_next = 1'b0;
                ST_S_D:
                begin
                    scl_next  = 1'b0;
                    reps_next = 3'd3;
                end
                ST_W_BIT:     sda_next = shift_next[7];
                ST_W_HI:      scl_next = 1'b1;
                ST_W_LO:      scl_next = 1'b0;
                ST_A_REL:     sda_next = 1'b1;
                ST_A_HI:      scl_next = 1'b1;
                ST_A_POLL:
                begin
                    polls_next = 8'd0;
                    reps_next  = 3'd0;
                end
                ST_A_OK:
                begin
                    scl_next  = 1'b0;
                    reps_next = 3'd3;
                end
                ST_A_FAIL:    scl_next = 1'b0;
                ST_DATA_WAIT: reps_next = 3'd0;
                ST_R_PRE:     reps_next = 3'd2;
                ST_R_REL:     sda_next = 1'b1;
                ST_R_LO:      scl_next = 1'b0;
                ST_R_HI:      scl_next = 1'b1;
                ST_R_END:     scl_next = 1'b0;
                // ack all but the last byte
                ST_P_SET:     sda_next = (left_next == 8'd0);
                ST_P_HI:      scl_next = 1'b1;
                ST_P_LO:
                begin
                    scl_next  = 1'b0;
                    reps_next = 3'd4;
                end
                ST_T_LOW:     sda_next = 1'b0;
                ST_T_HI:      scl_next = 1'b1;
                ST_T_REL:     sda_next = 1'b1;
                ST_T_WAIT:
                begin
                    reps_next = 3'd0;
                    swc_next  = stop_wait_ticks_reg;
                end
                default:      reps_next = 3'd1;
            endcase
        end
    end

    always_comb
    begin
        rsp_word.scl_level  = scl_next;
        rsp_word.sda_level  = sda_next;
        rsp_word.busy_res   = (step_next != ST_IDLE);
        rsp_word.need_data  = (step_next == ST_DATA_WAIT);
        rsp_word.read_valid = ev_valid;
        rsp_word.read_byte  = ev_byte;
        rsp_word.done_res   = ev_done;
        rsp_word.error      = ev_done && fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg     <= PHASE_TICKS_RST;
            stop_wait_ticks_reg <= STOP_WAIT_TICKS_RST;
            ack_poll_limit_reg  <= ACK_POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_TICKS:     phase_ticks_reg     <= cfg_data[7:0];
                REG_STOP_WAIT_TICKS: stop_wait_ticks_reg <= cfg_data;
                REG_ACK_POLL_LIMIT:  ack_poll_limit_reg  <= cfg_data[7:0];
                default:             phase_ticks_reg     <= phase_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            pc_reg    <= 8'd0;
            reps_reg  <= 3'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            left_reg  <= 8'd0;
            polls_reg <= 8'd0;
            swc_reg   <= 16'd0;
            rd_reg    <= 1'b0;
            tgt_reg   <= 7'd0;
            sub_reg   <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            role_reg  <= ROLE_ADDR;
            fail_reg  <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            pc_reg    <= pc_next;
            reps_reg  <= reps_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            polls_reg <= polls_next;
            swc_reg   <= swc_next;
            rd_reg    <= rd_next;
            tgt_reg   <= tgt_next;
            sub_reg   <= sub_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            role_reg  <= role_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

// ===== rtl/core/i2cm_outq.sv =====
// ----------------------------------------------------------------------------
// i2cm_outq
// Two-entry response queue between the sequencer and the result side.
// ----------------------------------------------------------------------------
module i2cm_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  i2cm_pkg::rsp_t wr_word,
    output logic           out_full,
    output logic           empty,
    input  logic           pop,
    output i2cm_pkg::rsp_t rsp
);
    import i2cm_pkg::*;

    rsp_t       head_reg;
    rsp_t       spare_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign out_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = wr && !out_full;
    assign do_pop   = pop && !empty;
    assign rsp      = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_reg <= spare_reg;
                if (do_push)
                begin
                    spare_reg <= wr_word;
                end
            end
            else if (do_push)
            begin
                head_reg <= wr_word;
            end
        end
        else if (do_push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= wr_word;
            end
            else
            begin
                spare_reg <= wr_word;
            end
        end
    end

endmodule

// ===== rtl/core/i2c_master_transaction_engine.sv =====
// path: a request word is registered in the front queue, and its response word in the
// response queue once the sequencer takes it, which waits while the response queue is full
// throughput: one word per cycle while the response queue has room; the sequencer settles
// each word combinationally, and two-entry queues at the front and the back keep both sides moving while one stalls
// reset (rst_n low, asynchronous): queues empty, sequencer idle, both lines released,
// registers back to phase_ticks 4, stop_wait_ticks 1000, ack_poll_limit 255
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master that steps SCL and SDA through bus phases paced by tick words.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  i2cm_pkg::req_t                        req,
    output logic                                  empty,
    input  logic                                  pop,
    output i2cm_pkg::rsp_t                        rsp,
    input  logic                                  cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import i2cm_pkg::*;

    cmd_chan_t chan;
    logic      fire;
    logic      out_full;
    rsp_t      seq_word;

    i2cm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .deq   (fire),
        .chan  (chan)
    );

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chan      (chan),
        .out_full  (out_full),
        .fire      (fire),
        .rsp_word  (seq_word)
    );

    i2cm_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (fire),
        .wr_word  (seq_word),
        .out_full (out_full),
        .empty    (empty),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the i2c master transaction engine.
// ----------------------------------------------------------------------------
module i2cm_port_checks (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input i2cm_pkg::rsp_t rsp
);
    import i2cm_pkg::*;

    // a waiting word holds until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("response word changed while stalled");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.error) |-> rsp.done_res)
        else $error("error without done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.done_res) |-> (!rsp.busy_res && !rsp.need_data))
        else $error("done while busy");

    a_need_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.need_data) |-> (rsp.busy_res && !rsp.read_valid))
        else $error("data request outside a write transaction");

    a_read_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.read_valid) |-> (rsp.read_byte == 8'd0))
        else $error("read byte without read valid");

endmodule

bind i2c_master_transaction_engine i2cm_port_checks u_port_checks (.*);
